@@ hdl/gki_pkg.sv @@
// grip keyframe interpolator package: table geometry, field widths, codes
// and the store address function; used by grip_keyframe_interpolator
package gki_pkg;

  localparam int GRIP_COUNT    = 8;
  localparam int ROWS_PER_GRIP = 8;
  localparam int FINGER_COUNT  = 5;
  localparam int COLS          = FINGER_COUNT + 1;
  localparam int STORE_DEPTH   = GRIP_COUNT * ROWS_PER_GRIP * COLS;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int ROW_W  = (ROWS_PER_GRIP > 2) ? $clog2(ROWS_PER_GRIP) : 1;
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int GRIP_W = 3;
  localparam int FIDX_W = 3;

  localparam int NUM_W = 17;
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam logic       CMD_WRITE   = 1'b0;
  localparam logic       CMD_MOVE    = 1'b1;
  localparam logic [1:0] DIR_OPEN    = 2'd1;
  localparam logic [1:0] DIR_CLOSE   = 2'd2;
  localparam logic [7:0] BLANK_WORD  = 8'hFF;
  localparam logic [6:0] FULL_SCALE  = 7'd100;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [GRIP_W-1:0] g,
                                                  input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'((int'(g) * ROWS_PER_GRIP + int'(r)) * COLS + int'(c));
  endfunction

endpackage

@@ hdl/grip_keyframe_interpolator.sv @@
// Grip keyframe interpolator: keyframe store, row scan, blank skip and a
// serial divider under one sequencer. Depends on gki_pkg.
//
// A write item (tuser = 0) stores one table word in the accept cycle and the
// block is ready again on the next cycle. A move item (tuser = 1) holds the
// input side for the whole move: a row scan with one read and compare per
// row tried, then for each finger the blank skips with one read per row
// visited, the reads of the two counts, the multiply and set-up, the
// restoring divider (passed over when the two counts are equal), the
// saturate step and the wait on the output. The single read port of the
// keyframe store and the one-bit-per-cycle divider set how long a move
// keeps the input side low. Results come in finger order, tlast on the last
// finger. A move with a grip beyond the table, or with no bracketing row
// pair, gives no result.
module grip_keyframe_interpolator
  import gki_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // grip_index[2:0], row_index[5:3], column_index[8:6], entry_value[16:9],
  // has_target[17], target_pos[25:18], direction[27:26], zero fill
  input  logic [31:0] s_tdata,
  // cmd
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // finger_index[2:0], finger_pos[9:3], table_fault[10], zero fill
  output logic [15:0] m_tdata,
  output logic        m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_A_RD, S_A_CHK, S_B_RD, S_B_CHK,
    S_CA_RD, S_CA_LD, S_CB_RD, S_CB_LD, S_MUL, S_DSET, S_DIV, S_FIX, S_OUT
  } state_t;

  state_t state;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata;
  logic [ADDR_W-1:0] raddr;

  logic [GRIP_W-1:0] in_grip;
  logic [2:0]        in_row, in_col;
  logic [7:0]        in_entry, in_target;
  logic              in_has_target;
  logic [1:0]        in_dir;
  logic signed [8:0] tgt_raw;
  logic [6:0]        tgt_clamped;

  logic [GRIP_W-1:0] grip;
  logic [6:0]        tgt;
  logic [ROW_W-1:0]  pair, ra, rb;
  logic [FIDX_W-1:0] f;
  logic [COL_W-1:0]  col;
  logic signed [7:0] cprev, pa, pb, ca, cb;
  logic signed [17:0] prod;
  logic signed [8:0] den;
  logic              eq;
  logic [NUM_W-1:0]  dq;
  logic [7:0]        dmag, rem;
  logic              neg;
  logic [CNT_W-1:0]  cnt;
  logic [8:0]        trial;
  logic signed [8:0] tdiff;
  logic signed [18:0] sum;
  logic signed [17:0] quo;

  logic [FIDX_W-1:0] out_idx;
  logic [6:0]        out_pos;
  logic              out_fault, out_last;

  assign in_grip       = s_tdata[2:0];
  assign in_row        = s_tdata[5:3];
  assign in_col        = s_tdata[8:6];
  assign in_entry      = s_tdata[16:9];
  assign in_has_target = s_tdata[17];
  assign in_target     = s_tdata[25:18];
  assign in_dir        = s_tdata[27:26];

  always_comb begin
    if (in_has_target) begin
      tgt_raw = 9'($signed(in_target));
    end else if (in_dir == DIR_OPEN) begin
      tgt_raw = '0;
    end else if (in_dir == DIR_CLOSE) begin
      tgt_raw = $signed({2'b00, FULL_SCALE});
    end else begin
      tgt_raw = -9'sd1;
    end
    if (tgt_raw < 0) begin
      tgt_clamped = '0;
    end else if (tgt_raw > $signed({2'b00, FULL_SCALE})) begin
      tgt_clamped = FULL_SCALE;
    end else begin
      tgt_clamped = tgt_raw[6:0];
    end
  end

  assign col = COL_W'(f) + COL_W'(1);

  always_comb begin
    unique case (state)
      S_SCAN_RD: raddr = cell_addr(grip, rb, '0);
      S_A_RD:    raddr = cell_addr(grip, ra, col);
      S_B_RD:    raddr = cell_addr(grip, rb, col);
      S_CA_RD:   raddr = cell_addr(grip, ra, '0);
      S_CB_RD:   raddr = cell_addr(grip, rb, '0);
      default:   raddr = '0;
    endcase
  end

  // keyframe store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser == CMD_WRITE &&
        int'(in_grip) < GRIP_COUNT && int'(in_row) < ROWS_PER_GRIP &&
        int'(in_col) < COLS) begin
      mem[cell_addr(in_grip, ROW_W'(in_row), COL_W'(in_col))] <= in_entry;
    end
    rdata <= mem[raddr];
  end

  assign tdiff = $signed({2'b00, tgt}) - 9'(ca);
  assign trial = {rem, dq[NUM_W-1]} - {1'b0, dmag};
  assign quo   = neg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});
  assign sum   = 19'(pa) + 19'(quo);

  assign s_tready = (state == S_IDLE) && !rst;
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {5'b0, out_fault, out_pos, out_idx};
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser == CMD_MOVE && int'(in_grip) < GRIP_COUNT) begin
            grip  <= in_grip;
            tgt   <= tgt_clamped;
            rb    <= '0;
            f     <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          cprev <= $signed(rdata);
          if (rb == '0) begin
            rb    <= ROW_W'(1);
            state <= S_SCAN_RD;
          end else if ($signed({1'b0, tgt}) >= cprev &&
                       $signed({1'b0, tgt}) <= $signed(rdata)) begin
            pair  <= rb - ROW_W'(1);
            ra    <= rb - ROW_W'(1);
            state <= S_A_RD;
          end else if (rb == ROW_W'(ROWS_PER_GRIP - 1)) begin
            state <= S_IDLE;
          end else begin
            rb    <= rb + ROW_W'(1);
            state <= S_SCAN_RD;
          end
        end
        S_A_RD: state <= S_A_CHK;
        S_A_CHK: begin
          if (rdata != BLANK_WORD) begin
            pa    <= $signed(rdata);
            state <= S_B_RD;
          end else if (ra == '0) begin
            out_idx   <= f;
            out_pos   <= '0;
            out_fault <= 1'b1;
            out_last  <= (int'(f) == FINGER_COUNT - 1);
            state     <= S_OUT;
          end else begin
            ra    <= ra - ROW_W'(1);
            state <= S_A_RD;
          end
        end
        S_B_RD: state <= S_B_CHK;
        S_B_CHK: begin
          if (rdata != BLANK_WORD) begin
            pb    <= $signed(rdata);
            state <= S_CA_RD;
          end else if (rb == ROW_W'(ROWS_PER_GRIP - 1)) begin
            out_idx   <= f;
            out_pos   <= '0;
            out_fault <= 1'b1;
            out_last  <= (int'(f) == FINGER_COUNT - 1);
            state     <= S_OUT;
          end else begin
            rb    <= rb + ROW_W'(1);
            state <= S_B_RD;
          end
        end
        S_CA_RD: state <= S_CA_LD;
        S_CA_LD: begin
          ca    <= $signed(rdata);
          state <= S_CB_RD;
        end
        S_CB_RD: state <= S_CB_LD;
        S_CB_LD: begin
          cb    <= $signed(rdata);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 18'(tdiff) * (18'(pb) - 18'(pa));
          den   <= 9'(cb) - 9'(ca);
          eq    <= (ca == cb);
          state <= S_DSET;
        end
        S_DSET: begin
          rem  <= '0;
          cnt  <= '0;
          neg  <= prod[17] ^ den[8];
          dq   <= eq ? '0 : (prod[17] ? NUM_W'(-prod) : NUM_W'(prod));
          dmag <= den[8] ? 8'(-den) : den[7:0];
          if (eq) begin
            state <= S_FIX;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (!trial[8] || rem[7]) begin
            rem <= 8'({rem, dq[NUM_W-1]} - {1'b0, dmag});
            dq  <= {dq[NUM_W-2:0], 1'b1};
          end else begin
            rem <= {rem[6:0], dq[NUM_W-1]};
            dq  <= {dq[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(NUM_W - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          out_idx   <= f;
          out_fault <= 1'b0;
          out_last  <= (int'(f) == FINGER_COUNT - 1);
          if (sum < 0) begin
            out_pos <= '0;
          end else if (sum > 19'sd127) begin
            out_pos <= 7'd127;
          end else begin
            out_pos <= sum[6:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) begin
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              f     <= f + FIDX_W'(1);
              ra    <= pair;
              rb    <= pair + ROW_W'(1);
              state <= S_A_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ test/tb_top.sv @@
// testbench for grip_keyframe_interpolator: loads keyframe tables, runs a
// directed table of moves and writes, then random traffic checked against
// an internal interpolation predictor. Depends on gki_pkg and the block.
`timescale 1ns / 100ps
module tb_top;
  import gki_pkg::*;

  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam int         RAND_ITEMS   = 36;
  localparam int         PRESET_GRIPS = 4;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_WAIT   = 300;
  localparam int         FULL         = int'(FULL_SCALE);

  typedef struct packed {
    logic [2:0] fidx;
    logic [6:0] pos;
    logic       fault;
    logic       last;
  } finger_res_t;

  typedef struct packed {
    logic       cmd;
    logic [2:0] grip;
    logic [2:0] row;
    logic [2:0] col;
    logic [7:0] value;
    logic       has_t;
    logic [7:0] target;
    logic [1:0] dir;
    logic       typed;
    logic [2:0] nres;
    logic [6:0] pos;
    logic       fault;
  } step_row_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = 32'd0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  logic signed [7:0] frame_word [GRIP_COUNT][ROWS_PER_GRIP][COLS];
  finger_res_t       pending_fingers [$];
  finger_res_t       got, want;
  step_row_t         steps [25];
  int                send_idle   = 19;
  int                recv_idle   = 84;
  int                err_count   = 0;
  int                cycle_count = 0;

  grip_keyframe_interpolator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] pack_item(input logic [2:0] g, r, c, input logic [7:0] v,
                                            input logic ht, input logic [7:0] tg,
                                            input logic [1:0] dr);
    pack_item = {4'b0, dr, tg, ht, v, c, r, g};
  endfunction

  task automatic predict_fingers(input logic [2:0] g, input logic has_t,
                                 input logic signed [7:0] tgt, input logic [1:0] dir);
    int          t, pair, ra, rb, pa, pb, ca, cb, pos;
    bit          found, fault;
    finger_res_t res;
    if (has_t) t = tgt;
    else if (dir == DIR_OPEN) t = 0;
    else if (dir == DIR_CLOSE) t = FULL;
    else t = -1;
    if (t < 0) t = 0;
    if (t > FULL) t = FULL;
    found = 0;
    pair = 0;
    for (int r = 0; r + 1 < ROWS_PER_GRIP; r++) begin
      if (!found && t >= frame_word[g][r][0] && t <= frame_word[g][r+1][0]) begin
        found = 1;
        pair = r;
      end
    end
    if (found) begin
      for (int f = 0; f < FINGER_COUNT; f++) begin
        ra = pair;
        rb = pair + 1;
        fault = 0;
        pos = 0;
        while (!fault && frame_word[g][ra][f+1] == BLANK_WORD) begin
          if (ra == 0) fault = 1;
          else ra--;
        end
        while (!fault && frame_word[g][rb][f+1] == BLANK_WORD) begin
          if (rb + 1 >= ROWS_PER_GRIP) fault = 1;
          else rb++;
        end
        if (!fault) begin
          pa = frame_word[g][ra][f+1];
          pb = frame_word[g][rb][f+1];
          ca = frame_word[g][ra][0];
          cb = frame_word[g][rb][0];
          if (ca == cb) pos = pa;
          else pos = pa + ((t - ca) * (pb - pa)) / (cb - ca);
          if (pos < 0) pos = 0;
          if (pos > 127) pos = 127;
        end
        res.fidx  = 3'(f);
        res.pos   = 7'(pos);
        res.fault = fault;
        res.last  = (f == FINGER_COUNT - 1);
        pending_fingers.push_back(res);
      end
    end
  endtask

  task automatic push_item(input logic cmd, input logic [31:0] data, input bit predict);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_WRITE) begin
      if (data[8:6] < COLS) frame_word[data[2:0]][data[5:3]][data[8:6]] = data[16:9];
    end else if (predict) begin
      predict_fingers(data[2:0], data[17], data[25:18], data[27:26]);
    end
  endtask

  task automatic load_grip(input logic [2:0] g, input bit preset);
    int val, cnt;
    cnt = $urandom_range(0, 9);
    for (int r = 0; r < ROWS_PER_GRIP; r++) begin
      if (r > 0) cnt += ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 28);
      if (cnt > 127) cnt = 127;
      for (int c = 0; c < COLS; c++) begin
        if (!preset)
          val = (c == 0) ? cnt : ($urandom_range(99) < 20) ? -1 : $urandom_range(0, 127);
        else if (c == 0)
          val = (g == 1) ? 50 : (r == 7) ? FULL : r * 10;
        else if ((g == 2 && (r == 3 || r == 4)) || (g == 3 && r == 7))
          val = -1;
        else
          val = (g == 1) ? r * 10 + 5 : (r == 7) ? 127 : r * 10;
        push_item(CMD_WRITE, pack_item(g, 3'(r), 3'(c), 8'(val), 1'($urandom_range(1)),
                                       8'($urandom_range(255)), 2'($urandom_range(2))),
                  1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[2:0], m_tdata[9:3], m_tdata[10], m_tlast};
        if (pending_fingers.size() == 0) begin
          $display("%0t: unexpected finger result idx=%0d pos=%0d fault=%0b last=%0b",
                   $time, got.fidx, got.pos, got.fault, got.last);
          err_count++;
        end else begin
          want = pending_fingers.pop_front();
          if (got != want) begin
            $display({"%0t: finger mismatch expected idx=%0d pos=%0d fault=%0b last=%0b",
                      " actual idx=%0d pos=%0d fault=%0b last=%0b"},
                     $time, want.fidx, want.pos, want.fault, want.last,
                     got.fidx, got.pos, got.fault, got.last);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    int          rand_items;
    int          pick;
    logic [7:0]  val;
    finger_res_t res;

    // preset grips: linear, flat counts, blank middle rows, blank last row
    steps[0]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0, 8'h00, DIR_OPEN,  1'b1, 3'd5, 7'd0,  1'b0};
    steps[1]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0, 8'h00, DIR_CLOSE, 1'b1, 3'd5, 7'd127, 1'b0};
    steps[2]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0, 8'h00, DIR_NONE,  1'b1, 3'd5, 7'd0,  1'b0};
    steps[3]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'h7F, DIR_NONE,  1'b1, 3'd5, 7'd127, 1'b0};
    steps[4]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'h80, DIR_CLOSE, 1'b1, 3'd5, 7'd0,  1'b0};
    steps[5]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'd55, DIR_NONE,  1'b1, 3'd5, 7'd55, 1'b0};
    steps[6]  = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'd10, DIR_OPEN,  1'b1, 3'd5, 7'd10, 1'b0};
    steps[7]  = '{CMD_MOVE, 3'd1, 3'd0, 3'd0, 8'h00, 1'b1, 8'd50, DIR_NONE,  1'b1, 3'd5, 7'd5,  1'b0};
    steps[8]  = '{CMD_MOVE, 3'd1, 3'd0, 3'd0, 8'h00, 1'b1, 8'd49, DIR_NONE,  1'b1, 3'd0, 7'd0,  1'b0};
    steps[9]  = '{CMD_MOVE, 3'd1, 3'd0, 3'd0, 8'h00, 1'b1, 8'd101, DIR_NONE, 1'b1, 3'd0, 7'd0,  1'b0};
    steps[10] = '{CMD_MOVE, 3'd2, 3'd0, 3'd0, 8'h00, 1'b1, 8'd35, DIR_NONE,  1'b1, 3'd5, 7'd35, 1'b0};
    steps[11] = '{CMD_MOVE, 3'd3, 3'd0, 3'd0, 8'h00, 1'b1, 8'd65, DIR_NONE,  1'b1, 3'd5, 7'd0,  1'b1};
    steps[12] = '{CMD_MOVE, 3'd3, 3'd0, 3'd0, 8'h00, 1'b1, 8'd55, DIR_NONE,  1'b1, 3'd5, 7'd55, 1'b0};
    steps[13] = '{CMD_WRITE, 3'd0, 3'd0, 3'd6, 8'h55, 1'b0, 8'h00, DIR_NONE, 1'b0, 3'd0, 7'd0,  1'b0};
    steps[14] = '{CMD_WRITE, 3'd0, 3'd0, 3'd7, 8'h00, 1'b0, 8'h00, DIR_NONE, 1'b0, 3'd0, 7'd0,  1'b0};
    steps[15] = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'd5,  DIR_NONE,  1'b1, 3'd5, 7'd5,  1'b0};
    for (int c = 1; c <= FINGER_COUNT; c++)
      steps[15 + c] = '{CMD_WRITE, 3'd0, 3'd0, 3'(c), BLANK_WORD, 1'b0, 8'h00, DIR_NONE,
                        1'b0, 3'd0, 7'd0, 1'b0};
    steps[21] = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'd5,  DIR_NONE,  1'b1, 3'd5, 7'd0,  1'b1};
    steps[22] = '{CMD_WRITE, 3'd0, 3'd0, 3'd1, 8'h7F, 1'b0, 8'h00, DIR_NONE, 1'b0, 3'd0, 7'd0,  1'b0};
    steps[23] = '{CMD_MOVE, 3'd0, 3'd0, 3'd0, 8'h00, 1'b1, 8'd4,  DIR_NONE,  1'b0, 3'd0, 7'd0,  1'b0};
    steps[24] = '{CMD_MOVE, 3'd2, 3'd5, 3'd2, 8'h00, 1'b1, 8'd40, DIR_CLOSE, 1'b0, 3'd0, 7'd0,  1'b0};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int g = 0; g < PRESET_GRIPS; g++) load_grip(3'(g), 1'b1);

    for (int i = 0; i < $size(steps); i++) begin
      push_item(steps[i].cmd, pack_item(steps[i].grip, steps[i].row, steps[i].col,
                steps[i].value, steps[i].has_t, steps[i].target, steps[i].dir),
                !steps[i].typed);
      if (steps[i].cmd == CMD_MOVE && steps[i].typed) begin
        for (int f = 0; f < steps[i].nres; f++) begin
          res.fidx  = 3'(f);
          res.pos   = steps[i].pos;
          res.fault = steps[i].fault;
          res.last  = (f == FINGER_COUNT - 1);
          pending_fingers.push_back(res);
        end
      end
    end

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      if (rand_items == RAND_ITEMS / 3) begin
        send_idle = 84;
        recv_idle = 19;
      end else if (rand_items == 2 * RAND_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end
      pick = $urandom_range(99);
      if (pick < 28) begin
        val = ($urandom_range(99) < 20) ? BLANK_WORD : 8'($urandom_range(0, 127));
        push_item(CMD_WRITE, pack_item(3'($urandom_range(PRESET_GRIPS - 1)),
                  3'($urandom_range(7)), 3'($urandom_range(0, 5)), val,
                  1'($urandom_range(1)), 8'($urandom_range(255)),
                  2'($urandom_range(2))), 1'b1);
      end else begin
        val = $urandom_range(1) ? 8'($urandom_range(0, 100)) : 8'($urandom_range(255));
        push_item(CMD_MOVE, pack_item(3'($urandom_range(PRESET_GRIPS - 1)),
                  3'($urandom_range(7)), 3'($urandom_range(0, 5)),
                  8'($urandom_range(255)), $urandom_range(99) < 65,
                  val, 2'($urandom_range(2))), 1'b1);
      end
      rand_items++;
    end
    s_tvalid <= 1'b0;

    while (pending_fingers.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
